// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the I2C bit-level master.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define AST_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/i2cbm_pkg.sv
// Types and constants of the I2C bit-level master.
// No dependencies; used by every module of the block.
package i2cbm_pkg;

   localparam int SCL_COUNT = 3;

   // Request type codes on the input channel.
   localparam logic [2:0] REQ_START   = 3'd0;
   localparam logic [2:0] REQ_STOP    = 3'd1;
   localparam logic [2:0] REQ_WRITE   = 3'd2;
   localparam logic [2:0] REQ_READ    = 3'd3;
   localparam logic [2:0] REQ_RECOVER = 3'd4;
   localparam logic [2:0] REQ_TICK    = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] REG_RECOVER_CLOCKS = 2'd0;
   localparam logic [1:0] REG_CLEAR_TRIES    = 2'd1;
   localparam logic [1:0] REG_RELEASE_WAIT   = 2'd2;

   localparam logic [7:0] RECOVER_CLOCKS_RST = 8'd80;
   localparam logic [7:0] CLEAR_TRIES_RST    = 8'd10;
   localparam logic [7:0] RELEASE_WAIT_RST   = 8'd10;

   // Phases of start, stop, write and read sequences.
   localparam logic [3:0] PH_SCL_HI = 4'd0;
   localparam logic [3:0] PH_HOLD   = 4'd1;
   localparam logic [3:0] PH_SCL_LO = 4'd2;
   localparam logic [3:0] PH_ACK_HI = 4'd3;
   localparam logic [3:0] PH_ACK_LO = 4'd4;
   localparam logic [3:0] PH_END    = 4'd5;

   // Phases of the recovery sequence.
   localparam logic [3:0] RC_PULSE_LO  = 4'd0;
   localparam logic [3:0] RC_PULSE_HI  = 4'd1;
   localparam logic [3:0] RC_PULSE_CNT = 4'd2;
   localparam logic [3:0] RC_CLR_HI    = 4'd3;
   localparam logic [3:0] RC_CLR_HOLD  = 4'd4;
   localparam logic [3:0] RC_CLR_LO    = 4'd5;
   localparam logic [3:0] RC_CLR_CHK   = 4'd6;
   localparam logic [3:0] RC_RST_SDA   = 4'd7;
   localparam logic [3:0] RC_RST_LO    = 4'd8;
   localparam logic [3:0] RC_RST_HI    = 4'd9;
   localparam logic [3:0] RC_RST_REL   = 4'd10;
   localparam logic [3:0] RC_WAIT_LOAD = 4'd11;
   localparam logic [3:0] RC_WAIT      = 4'd12;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ,
      CMD_RECOVER,
      CMD_TICK
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_STOP,
      ST_WRITE,
      ST_READ,
      ST_RECOVER
   } state_type;

   typedef struct packed {
      cmd_type    kind;
      logic [1:0] bus;
      logic [7:0] wr_byte;
      logic       last;
      logic       sda;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic [7:0] recover_clocks;
      logic [7:0] clear_tries;
      logic [7:0] release_wait;
   } cfg_type;

endpackage

// File: hw/rtl/i2c_bit_level_master_core.sv
// I2C bit-level master: one result per request. A taken request is decoded into a
// two-entry queue, then one sequencer step registers its result in the output register.
// Throughput is one request per cycle while rsp_stall does not hold the sequencer.
// Reset is synchronous: SCL lines and SDA released high, sequencer idle,
// configuration back to 80 recovery clocks, 10 clear tries and 10 wait ticks.
`include "assert_macros.svh"
module i2c_bit_level_master_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [1:0]  req_bus_sel,
   input  logic [7:0]  req_wr_byte,
   input  logic        req_read_last,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_scl_lines,
   output logic        rsp_sda_level,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_seen,
   output logic        rsp_recover_fail,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   i2cbm_pkg::item_type     front_item;
   i2cbm_pkg::item_type     head;
   i2cbm_pkg::q_status_type q_status;
   i2cbm_pkg::cfg_type      cfg;
   logic                    push;
   logic                    pop;
   logic                    cfg_write;
   logic [1:0]              reg_index;
   logic [7:0]              recover_clocks_ff, recover_clocks_in;
   logic [7:0]              clear_tries_ff, clear_tries_in;
   logic [7:0]              release_wait_ff, release_wait_in;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign reg_index = paddr[3:2];

   always_comb begin
      recover_clocks_in = recover_clocks_ff;
      clear_tries_in    = clear_tries_ff;
      release_wait_in   = release_wait_ff;
      if (cfg_write) begin
         case (reg_index)
            i2cbm_pkg::REG_RECOVER_CLOCKS: recover_clocks_in = pwdata[7:0];
            i2cbm_pkg::REG_CLEAR_TRIES:    clear_tries_in    = pwdata[7:0];
            i2cbm_pkg::REG_RELEASE_WAIT:   release_wait_in   = pwdata[7:0];
            default:                       recover_clocks_in = recover_clocks_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recover_clocks_ff <= i2cbm_pkg::RECOVER_CLOCKS_RST;
         clear_tries_ff    <= i2cbm_pkg::CLEAR_TRIES_RST;
         release_wait_ff   <= i2cbm_pkg::RELEASE_WAIT_RST;
      end else begin
         recover_clocks_ff <= recover_clocks_in;
         clear_tries_ff    <= clear_tries_in;
         release_wait_ff   <= release_wait_in;
      end
   end

   always_comb begin
      case (reg_index)
         i2cbm_pkg::REG_RECOVER_CLOCKS: prdata = {24'd0, recover_clocks_ff};
         i2cbm_pkg::REG_CLEAR_TRIES:    prdata = {24'd0, clear_tries_ff};
         i2cbm_pkg::REG_RELEASE_WAIT:   prdata = {24'd0, release_wait_ff};
         default:                       prdata = 32'd0;
      endcase
   end

   assign cfg.recover_clocks = recover_clocks_ff;
   assign cfg.clear_tries    = clear_tries_ff;
   assign cfg.release_wait   = release_wait_ff;

   assign req_stall = q_status.full;
   assign push      = req_valid && !req_stall;

   i2cbm_front u_front (
      .req_type  (req_type),
      .bus_sel   (req_bus_sel),
      .wr_byte   (req_wr_byte),
      .read_last (req_read_last),
      .sda_in    (req_sda_in),
      .item      (front_item)
   );

   i2cbm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   i2cbm_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_status     (q_status),
      .cfg          (cfg),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .scl_lines    (rsp_scl_lines),
      .sda_level    (rsp_sda_level),
      .busy_res     (rsp_busy_res),
      .done_res     (rsp_done_res),
      .rx_byte      (rsp_rx_byte),
      .ack_seen     (rsp_ack_seen),
      .recover_fail (rsp_recover_fail)
   );

   // A finished sequence always leaves the sequencer idle.
   `AST_IMP(a_done_idle, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res, "done while busy")

   // With nothing queued, a delivered result cannot be followed by a new one.
   `AST_NEXT(a_no_phantom, clock, reset, rsp_valid && !rsp_stall && q_status.empty, !rsp_valid, "result without request")

   // The recovery failure flag is only raised at the end of a recovery.
   `AST_IMP(a_fail_at_done, clock, reset, $rose(rsp_recover_fail), rsp_done_res, "failure flag raised mid-sequence")

endmodule

// File: hw/rtl/i2cbm_front.sv
// Front end of the I2C bit-level master: decodes a request into a command.
// Depends on i2cbm_pkg.
module i2cbm_front (
   input  logic [2:0]         req_type,
   input  logic [1:0]         bus_sel,
   input  logic [7:0]         wr_byte,
   input  logic               read_last,
   input  logic               sda_in,
   output i2cbm_pkg::item_type item
);

   logic bus_ok;

   assign bus_ok = (32'(bus_sel) < i2cbm_pkg::SCL_COUNT);

   always_comb begin
      item.bus     = bus_sel;
      item.wr_byte = wr_byte;
      item.last    = read_last;
      item.sda     = sda_in;
      case (req_type)
         i2cbm_pkg::REQ_START: begin
            item.kind = bus_ok ? i2cbm_pkg::CMD_START : i2cbm_pkg::CMD_NONE;
         end
         i2cbm_pkg::REQ_STOP: begin
            item.kind = bus_ok ? i2cbm_pkg::CMD_STOP : i2cbm_pkg::CMD_NONE;
         end
         i2cbm_pkg::REQ_WRITE: begin
            item.kind = bus_ok ? i2cbm_pkg::CMD_WRITE : i2cbm_pkg::CMD_NONE;
         end
         i2cbm_pkg::REQ_READ: begin
            item.kind = bus_ok ? i2cbm_pkg::CMD_READ : i2cbm_pkg::CMD_NONE;
         end
         i2cbm_pkg::REQ_RECOVER: item.kind = i2cbm_pkg::CMD_RECOVER;
         i2cbm_pkg::REQ_TICK:    item.kind = i2cbm_pkg::CMD_TICK;
         default:                item.kind = i2cbm_pkg::CMD_NONE;
      endcase
   end

endmodule

// File: hw/rtl/i2cbm_queue.sv
// Two-entry queue of decoded commands between front end and sequencer.
// Depends on i2cbm_pkg.
module i2cbm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  i2cbm_pkg::item_type     push_item,
   input  logic                    pop,
   output i2cbm_pkg::item_type     head,
   output i2cbm_pkg::q_status_type status
);

   i2cbm_pkg::item_type slot_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);

endmodule

// File: hw/rtl/i2cbm_engine.sv
// Pin sequencer of the I2C bit-level master: runs one command per queue entry
// and holds the result in its output register. Depends on i2cbm_pkg.
module i2cbm_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  i2cbm_pkg::item_type                   head,
   input  i2cbm_pkg::q_status_type               q_status,
   input  i2cbm_pkg::cfg_type                    cfg,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [i2cbm_pkg::SCL_COUNT-1:0]       scl_lines,
   output logic                                  sda_level,
   output logic                                  busy_res,
   output logic                                  done_res,
   output logic [7:0]                            rx_byte,
   output logic                                  ack_seen,
   output logic                                  recover_fail
);

   i2cbm_pkg::state_type                 state_ff, state_in;
   logic [3:0]                           phase_ff, phase_in;
   logic [3:0]                           bit_left_ff, bit_left_in;
   logic [7:0]                           shift_ff, shift_in;
   logic [1:0]                           bus_ff, bus_in;
   logic [i2cbm_pkg::SCL_COUNT-1:0]      scl_ff, scl_in;
   logic                                 sda_ff, sda_in;
   logic [7:0]                           retry_ff, retry_in;
   logic                                 last_ff, last_in;
   logic                                 ack_ff, ack_in;
   logic [7:0]                           rx_ff, rx_in;
   logic                                 fail_ff, fail_in;
   logic                                 done_ff, done_in;
   logic                                 valid_ff, valid_in;

   // The state registers double as the output register: they only move when
   // the previous result has been taken or no result is held.
   assign pop = !q_status.empty && (!valid_ff || !rsp_stall);

   always_comb begin
      logic fin;
      logic [3:0] bl_dec;
      logic [7:0] sh_next;
      fin         = 1'b0;
      bl_dec      = bit_left_ff - 4'd1;
      sh_next     = 8'd0;
      state_in    = state_ff;
      phase_in    = phase_ff;
      bit_left_in = bit_left_ff;
      shift_in    = shift_ff;
      bus_in      = bus_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      retry_in    = retry_ff;
      last_in     = last_ff;
      ack_in      = ack_ff;
      rx_in       = rx_ff;
      fail_in     = fail_ff;
      done_in     = done_ff;
      valid_in    = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
         done_in  = 1'b0;
         if (head.kind == i2cbm_pkg::CMD_TICK) begin
            case (state_ff)
               i2cbm_pkg::ST_START: begin
                  case (phase_ff)
                     i2cbm_pkg::PH_SCL_HI: begin
                        scl_in[bus_ff] = 1'b1;
                        phase_in = i2cbm_pkg::PH_HOLD;
                     end
                     i2cbm_pkg::PH_HOLD: begin
                        sda_in   = 1'b0;
                        phase_in = i2cbm_pkg::PH_SCL_LO;
                     end
                     default: begin
                        scl_in[bus_ff] = 1'b0;
                        fin = 1'b1;
                     end
                  endcase
               end
               i2cbm_pkg::ST_STOP: begin
                  case (phase_ff)
                     i2cbm_pkg::PH_SCL_HI: begin
                        sda_in   = 1'b0;
                        phase_in = i2cbm_pkg::PH_HOLD;
                     end
                     i2cbm_pkg::PH_HOLD: begin
                        scl_in[bus_ff] = 1'b1;
                        phase_in = i2cbm_pkg::PH_SCL_LO;
                     end
                     default: begin
                        sda_in = 1'b1;
                        fin    = 1'b1;
                     end
                  endcase
               end
               i2cbm_pkg::ST_WRITE: begin
                  case (phase_ff)
                     i2cbm_pkg::PH_SCL_HI: begin
                        scl_in[bus_ff] = 1'b1;
                        phase_in = i2cbm_pkg::PH_HOLD;
                     end
                     i2cbm_pkg::PH_HOLD: phase_in = i2cbm_pkg::PH_SCL_LO;
                     i2cbm_pkg::PH_SCL_LO: begin
                        scl_in[bus_ff] = 1'b0;
                        shift_in    = {shift_ff[6:0], 1'b0};
                        bit_left_in = bl_dec;
                        if (bl_dec != 4'd0) begin
                           sda_in   = shift_ff[6];
                           phase_in = i2cbm_pkg::PH_SCL_HI;
                        end else begin
                           sda_in   = 1'b1;
                           phase_in = i2cbm_pkg::PH_ACK_HI;
                        end
                     end
                     i2cbm_pkg::PH_ACK_HI: begin
                        scl_in[bus_ff] = 1'b1;
                        phase_in = i2cbm_pkg::PH_ACK_LO;
                     end
                     i2cbm_pkg::PH_ACK_LO: begin
                        ack_in = ~head.sda;
                        scl_in[bus_ff] = 1'b0;
                        phase_in = i2cbm_pkg::PH_END;
                     end
                     default: begin
                        sda_in = 1'b0;
                        fin    = 1'b1;
                     end
                  endcase
               end
               i2cbm_pkg::ST_READ: begin
                  case (phase_ff)
                     i2cbm_pkg::PH_SCL_HI: begin
                        scl_in[bus_ff] = 1'b1;
                        phase_in = i2cbm_pkg::PH_HOLD;
                     end
                     i2cbm_pkg::PH_HOLD: phase_in = i2cbm_pkg::PH_SCL_LO;
                     i2cbm_pkg::PH_SCL_LO: begin
                        sh_next     = {shift_ff[6:0], head.sda};
                        shift_in    = sh_next;
                        scl_in[bus_ff] = 1'b0;
                        bit_left_in = bl_dec;
                        if (bl_dec != 4'd0) begin
                           phase_in = i2cbm_pkg::PH_SCL_HI;
                        end else begin
                           rx_in = sh_next;
                           if (!last_ff) begin
                              sda_in = 1'b0;
                           end
                           phase_in = i2cbm_pkg::PH_ACK_HI;
                        end
                     end
                     i2cbm_pkg::PH_ACK_HI: begin
                        scl_in[bus_ff] = 1'b1;
                        phase_in = i2cbm_pkg::PH_ACK_LO;
                     end
                     default: begin
                        scl_in[bus_ff] = 1'b0;
                        fin = 1'b1;
                     end
                  endcase
               end
               i2cbm_pkg::ST_RECOVER: begin
                  case (phase_ff)
                     i2cbm_pkg::RC_PULSE_LO: begin
                        scl_in   = '0;
                        phase_in = i2cbm_pkg::RC_PULSE_HI;
                     end
                     i2cbm_pkg::RC_PULSE_HI: begin
                        scl_in   = '1;
                        phase_in = i2cbm_pkg::RC_PULSE_CNT;
                     end
                     i2cbm_pkg::RC_PULSE_CNT: begin
                        if (retry_ff != 8'd1) begin
                           retry_in = retry_ff - 8'd1;
                           phase_in = i2cbm_pkg::RC_PULSE_LO;
                        end else if (!head.sda && cfg.clear_tries != 8'd0) begin
                           retry_in = cfg.clear_tries - 8'd1;
                           phase_in = i2cbm_pkg::RC_CLR_HI;
                        end else begin
                           retry_in = cfg.clear_tries;
                           phase_in = i2cbm_pkg::RC_RST_SDA;
                        end
                     end
                     i2cbm_pkg::RC_CLR_HI: begin
                        scl_in   = '1;
                        phase_in = i2cbm_pkg::RC_CLR_HOLD;
                     end
                     i2cbm_pkg::RC_CLR_HOLD: phase_in = i2cbm_pkg::RC_CLR_LO;
                     i2cbm_pkg::RC_CLR_LO: begin
                        scl_in   = '0;
                        phase_in = i2cbm_pkg::RC_CLR_CHK;
                     end
                     i2cbm_pkg::RC_CLR_CHK: begin
                        scl_in = '1;
                        if (!head.sda && retry_ff != 8'd0) begin
                           retry_in = retry_ff - 8'd1;
                           phase_in = i2cbm_pkg::RC_CLR_HI;
                        end else begin
                           phase_in = i2cbm_pkg::RC_RST_SDA;
                        end
                     end
                     i2cbm_pkg::RC_RST_SDA: begin
                        sda_in   = 1'b0;
                        phase_in = i2cbm_pkg::RC_RST_LO;
                     end
                     i2cbm_pkg::RC_RST_LO: begin
                        scl_in[0] = 1'b0;
                        phase_in  = i2cbm_pkg::RC_RST_HI;
                     end
                     i2cbm_pkg::RC_RST_HI: begin
                        scl_in[0] = 1'b1;
                        phase_in  = i2cbm_pkg::RC_RST_REL;
                     end
                     i2cbm_pkg::RC_RST_REL: begin
                        sda_in   = 1'b1;
                        phase_in = i2cbm_pkg::RC_WAIT_LOAD;
                     end
                     i2cbm_pkg::RC_WAIT_LOAD: begin
                        if (!head.sda && cfg.release_wait != 8'd0) begin
                           retry_in = cfg.release_wait - 8'd1;
                           phase_in = i2cbm_pkg::RC_WAIT;
                        end else begin
                           retry_in = cfg.release_wait;
                           fail_in  = (cfg.release_wait == 8'd0);
                           fin      = 1'b1;
                        end
                     end
                     default: begin
                        if (!head.sda && retry_ff != 8'd0) begin
                           retry_in = retry_ff - 8'd1;
                           phase_in = i2cbm_pkg::RC_WAIT;
                        end else begin
                           fail_in = (retry_ff == 8'd0);
                           fin     = 1'b1;
                        end
                     end
                  endcase
               end
               default: fin = 1'b0;
            endcase
            if (fin) begin
               state_in = i2cbm_pkg::ST_IDLE;
               phase_in = 4'd0;
            end
            done_in = fin;
         end else if (state_ff == i2cbm_pkg::ST_IDLE) begin
            case (head.kind)
               i2cbm_pkg::CMD_START: begin
                  state_in = i2cbm_pkg::ST_START;
                  bus_in   = head.bus;
                  phase_in = 4'd0;
                  sda_in   = 1'b1;
               end
               i2cbm_pkg::CMD_STOP: begin
                  state_in = i2cbm_pkg::ST_STOP;
                  bus_in   = head.bus;
                  phase_in = 4'd0;
                  scl_in[head.bus] = 1'b0;
               end
               i2cbm_pkg::CMD_WRITE: begin
                  state_in    = i2cbm_pkg::ST_WRITE;
                  bus_in      = head.bus;
                  phase_in    = 4'd0;
                  ack_in      = 1'b0;
                  bit_left_in = 4'd8;
                  shift_in    = head.wr_byte;
                  sda_in      = head.wr_byte[7];
               end
               i2cbm_pkg::CMD_READ: begin
                  state_in    = i2cbm_pkg::ST_READ;
                  bus_in      = head.bus;
                  phase_in    = 4'd0;
                  bit_left_in = 4'd8;
                  shift_in    = 8'd0;
                  last_in     = head.last;
                  sda_in      = 1'b1;
               end
               i2cbm_pkg::CMD_RECOVER: begin
                  state_in = i2cbm_pkg::ST_RECOVER;
                  fail_in  = 1'b0;
                  phase_in = i2cbm_pkg::RC_PULSE_LO;
                  retry_in = cfg.recover_clocks;
                  // With no pulses asked for, the stuck-SDA check runs at once.
                  if (cfg.recover_clocks == 8'd0) begin
                     if (!head.sda && cfg.clear_tries != 8'd0) begin
                        retry_in = cfg.clear_tries - 8'd1;
                        phase_in = i2cbm_pkg::RC_CLR_HI;
                     end else begin
                        retry_in = cfg.clear_tries;
                        phase_in = i2cbm_pkg::RC_RST_SDA;
                     end
                  end
               end
               default: state_in = state_ff;
            endcase
         end
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= i2cbm_pkg::ST_IDLE;
         phase_ff    <= 4'd0;
         bit_left_ff <= 4'd0;
         shift_ff    <= 8'd0;
         bus_ff      <= 2'd0;
         scl_ff      <= '1;
         sda_ff      <= 1'b1;
         retry_ff    <= 8'd0;
         last_ff     <= 1'b0;
         ack_ff      <= 1'b0;
         rx_ff       <= 8'd0;
         fail_ff     <= 1'b0;
         done_ff     <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         bit_left_ff <= bit_left_in;
         shift_ff    <= shift_in;
         bus_ff      <= bus_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in;
         retry_ff    <= retry_in;
         last_ff     <= last_in;
         ack_ff      <= ack_in;
         rx_ff       <= rx_in;
         fail_ff     <= fail_in;
         done_ff     <= done_in;
         valid_ff    <= valid_in;
      end
   end

   always_comb begin
      rsp_valid    = valid_ff;
      scl_lines    = scl_ff;
      sda_level    = sda_ff;
      busy_res     = (state_ff != i2cbm_pkg::ST_IDLE);
      done_res     = done_ff;
      rx_byte      = rx_ff;
      ack_seen     = ack_ff;
      recover_fail = fail_ff;
   end

endmodule
